[sv/shrp_pkg.sv]
// shared types and constants for the sensor hub report parser
// no dependencies; imported by every module of the block
package shrp_pkg;

  localparam int LEN_W       = 15;
  localparam int QUEUE_DEPTH = 2;

  // packet end events passed from front to back
  localparam logic [1:0] EV_END   = 2'd0;
  localparam logic [1:0] EV_EMPTY = 2'd1;
  localparam logic [1:0] EV_ERR   = 2'd2;

  // result status codes
  localparam logic [1:0] ST_DECODED = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_LEN_ERR = 2'd2;

  // report kinds
  localparam logic [2:0] KIND_NONE     = 3'd0;
  localparam logic [2:0] KIND_ROTATION = 3'd1;
  localparam logic [2:0] KIND_LIN_ACC  = 3'd2;
  localparam logic [2:0] KIND_GYRO     = 3'd3;
  localparam logic [2:0] KIND_GRAVITY  = 3'd4;
  localparam logic [2:0] KIND_MAGNETIC = 3'd5;

  // report ids
  localparam logic [7:0] RID_GYRO     = 8'h02;
  localparam logic [7:0] RID_MAGNETIC = 8'h03;
  localparam logic [7:0] RID_LIN_ACC  = 8'h04;
  localparam logic [7:0] RID_ROT      = 8'h05;
  localparam logic [7:0] RID_GRAVITY  = 8'h06;
  localparam logic [7:0] RID_GAME_ROT = 8'h08;

  // channels that carry sensor reports
  localparam logic [7:0] CH_REPORT   = 8'd3;
  localparam logic [7:0] CH_WAKE     = 8'd4;

  localparam logic [LEN_W-1:0] HDR_LEN   = LEN_W'(4);
  localparam logic [LEN_W-1:0] NEED_ROT  = LEN_W'(14);
  localparam logic [LEN_W-1:0] NEED_AXIS = LEN_W'(10);

  typedef struct packed {
    logic [1:0]       ev;
    logic [7:0]       channel;
    logic [7:0]       rpt_id;
    logic [LEN_W-1:0] length;
    logic [3:0][15:0] vals;
  } desc_t;

endpackage

[sv/sensor_hub_report_parser.sv]
// sensor hub report parser: one byte per cycle while in_stall is low, at most one result per packet
// a result passes from the last packet byte through the queue, then the output register, to out_valid
// throughput: one byte every cycle; in_stall rises only while the 2-entry queue is full
// reset: synchronous active-low rst_n drops any packet and waits for a start byte
// depends on shrp_pkg, shrp_front, shrp_queue and shrp_back
module sensor_hub_report_parser import shrp_pkg::*; #(
  parameter int MAX_PACKET = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_data_byte,
  input  logic               in_start_req,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [2:0]         out_report_kind,
  output logic [7:0]         out_packet_channel,
  output logic signed [15:0] out_value_x,
  output logic signed [15:0] out_value_y,
  output logic signed [15:0] out_value_z,
  output logic signed [15:0] out_value_w,
  output logic [6:0]         out_payload_length
);

  logic  q_full, q_push, q_pop, q_empty;
  desc_t q_wdata, q_rdata;

  shrp_front #(.MAX_PACKET(MAX_PACKET)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_start_req (in_start_req),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_desc       (q_wdata)
  );

  shrp_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  shrp_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_head             (q_rdata),
    .q_empty            (q_empty),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_report_kind    (out_report_kind),
    .out_packet_channel (out_packet_channel),
    .out_value_x        (out_value_x),
    .out_value_y        (out_value_y),
    .out_value_z        (out_value_z),
    .out_value_w        (out_value_w),
    .out_payload_length (out_payload_length)
  );

endmodule

[sv/shrp_front.sv]
// byte-level packet framing: header capture, length check, payload capture
// depends on shrp_pkg; pushes one descriptor per finished packet
module shrp_front import shrp_pkg::*; #(
  parameter int MAX_PACKET = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_start_req,
  input  logic       q_full,
  output logic       q_push,
  output desc_t      q_desc
);

  localparam int POS_W = $clog2(MAX_PACKET);
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PACKET);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             disc_r, disc_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [7:0]       chan_r, chan_nxt;
  logic [7:0]       rid_r, rid_nxt;
  logic [3:0][15:0] vals_r, vals_nxt;

  logic             active;
  logic [POS_W-1:0] eff_pos;
  logic [LEN_W:0]   pos_inc;

  assign in_stall = q_full;

  always_comb begin
    active   = in_valid && !q_full && (in_start_req || !disc_r);
    eff_pos  = in_start_req ? '0 : pos_r;
    pos_inc  = (LEN_W+1)'(eff_pos) + (LEN_W+1)'(1);
    pos_nxt  = pos_r;
    disc_nxt = disc_r;
    len_nxt  = len_r;
    chan_nxt = chan_r;
    rid_nxt  = rid_r;
    vals_nxt = vals_r;
    q_push   = 1'b0;
    q_desc.ev = EV_END;
    if (active) begin
      disc_nxt = 1'b0;
      pos_nxt  = eff_pos + POS_W'(1);
      if (eff_pos == POS_W'(0)) begin
        len_nxt = LEN_W'(in_data_byte);
      end else if (eff_pos == POS_W'(1)) begin
        len_nxt = {in_data_byte[6:0], len_r[7:0]};
      end else if (eff_pos == POS_W'(2)) begin
        chan_nxt = in_data_byte;
      end else if (eff_pos == POS_W'(3)) begin
        if (len_r < HDR_LEN || len_r > MAX_LEN) begin
          q_push    = 1'b1;
          q_desc.ev = EV_ERR;
          disc_nxt  = 1'b1;
        end else if (len_r == HDR_LEN) begin
          q_push    = 1'b1;
          q_desc.ev = EV_EMPTY;
          disc_nxt  = 1'b1;
        end
      end else begin
        if (eff_pos == POS_W'(4)) begin
          rid_nxt = in_data_byte;
        end
        // payload bytes 4..11 land in the four value words
        if (eff_pos[POS_W-1:3] == (POS_W-3)'(1)) begin
          if (eff_pos[0]) begin
            vals_nxt[eff_pos[2:1]][15:8] = in_data_byte;
          end else begin
            vals_nxt[eff_pos[2:1]][7:0] = in_data_byte;
          end
        end
        if (pos_inc >= {1'b0, len_r}) begin
          q_push    = 1'b1;
          q_desc.ev = EV_END;
          disc_nxt  = 1'b1;
        end
      end
    end
    q_desc.channel = chan_nxt;
    q_desc.rpt_id  = rid_nxt;
    q_desc.length  = len_nxt;
    q_desc.vals    = vals_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      disc_r <= 1'b1;
    end else begin
      pos_r  <= pos_nxt;
      disc_r <= disc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r  <= len_nxt;
    chan_r <= chan_nxt;
    rid_r  <= rid_nxt;
    vals_r <= vals_nxt;
  end

endmodule

[sv/shrp_queue.sv]
// short descriptor queue between framing and decode
// depends on shrp_pkg for desc_t and the queue depth
module shrp_queue import shrp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t wdata,
  output logic  full,
  input  logic  pop,
  output desc_t rdata,
  output logic  empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  desc_t            mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   count_r, count_nxt;

  assign full  = (count_r == (PTR_W+1)'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + (PTR_W+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full)) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty)) else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (PTR_W+1)'(QUEUE_DEPTH)) else $error("queue count out of range");

endmodule

[sv/shrp_back.sv]
// report decode and output register
// depends on shrp_pkg; pops descriptors from shrp_queue
module shrp_back import shrp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  desc_t              q_head,
  input  logic               q_empty,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [2:0]         out_report_kind,
  output logic [7:0]         out_packet_channel,
  output logic signed [15:0] out_value_x,
  output logic signed [15:0] out_value_y,
  output logic signed [15:0] out_value_z,
  output logic signed [15:0] out_value_w,
  output logic [6:0]         out_payload_length
);

  logic        valid_r, valid_nxt;
  logic [1:0]  status_r, status_nxt;
  logic [2:0]  kind_r, kind_nxt;
  logic [7:0]  chan_r;
  logic [15:0] x_r, y_r, z_r, w_r;
  logic [15:0] x_nxt, y_nxt, z_nxt, w_nxt;
  logic [6:0]  plen_r, plen_nxt;

  logic [2:0]       kind_dec;
  logic [LEN_W-1:0] plen_full;
  logic [LEN_W-1:0] need;

  assign q_pop     = !q_empty && (!valid_r || !out_stall);
  assign plen_full = q_head.length - HDR_LEN;

  always_comb begin
    kind_dec = KIND_NONE;
    if (q_head.channel == CH_REPORT || q_head.channel == CH_WAKE) begin
      unique case (q_head.rpt_id)
        RID_ROT, RID_GAME_ROT: kind_dec = KIND_ROTATION;
        RID_LIN_ACC:           kind_dec = KIND_LIN_ACC;
        RID_GYRO:              kind_dec = KIND_GYRO;
        RID_GRAVITY:           kind_dec = KIND_GRAVITY;
        RID_MAGNETIC:          kind_dec = KIND_MAGNETIC;
        default:               kind_dec = KIND_NONE;
      endcase
    end
    need = (kind_dec == KIND_ROTATION) ? NEED_ROT : NEED_AXIS;

    status_nxt = ST_IGNORED;
    kind_nxt   = KIND_NONE;
    x_nxt      = '0;
    y_nxt      = '0;
    z_nxt      = '0;
    w_nxt      = '0;
    plen_nxt   = '0;
    unique case (q_head.ev)
      EV_ERR: begin
        status_nxt = ST_LEN_ERR;
      end
      EV_EMPTY: begin
        status_nxt = ST_IGNORED;
      end
      EV_END: begin
        plen_nxt = plen_full[6:0];
        if (kind_dec != KIND_NONE && plen_full >= need) begin
          status_nxt = ST_DECODED;
          kind_nxt   = kind_dec;
          x_nxt      = q_head.vals[0];
          y_nxt      = q_head.vals[1];
          z_nxt      = q_head.vals[2];
          if (kind_dec == KIND_ROTATION) begin
            w_nxt = q_head.vals[3];
          end
        end
      end
      default: begin
        status_nxt = ST_IGNORED;
      end
    endcase

    if (q_pop) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      status_r <= status_nxt;
      kind_r   <= kind_nxt;
      chan_r   <= q_head.channel;
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      z_r      <= z_nxt;
      w_r      <= w_nxt;
      plen_r   <= plen_nxt;
    end
  end

  assign out_valid          = valid_r;
  assign out_status         = status_r;
  assign out_report_kind    = kind_r;
  assign out_packet_channel = chan_r;
  assign out_value_x        = x_r;
  assign out_value_y        = y_r;
  assign out_value_z        = z_r;
  assign out_value_w        = w_r;
  assign out_payload_length = plen_r;

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && status_r == ST_LEN_ERR) |->
      (kind_r == KIND_NONE && plen_r == '0 && x_r == '0 && w_r == '0))
    else $error("length error result carries data");
  a_decoded_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && status_r == ST_DECODED) |-> (kind_r != KIND_NONE))
    else $error("decoded result without kind");
  a_w_rotation: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && w_r != '0) |-> (kind_r == KIND_ROTATION))
    else $error("w component on non-rotation report");

endmodule
